>>> hdl/iqea_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iqea_pkg
// Shared types and constants for the int8 quantized elementwise add unit.
// ----------------------------------------------------------------------------
package iqea_pkg;

	// element and register widths
	localparam int ELEM_W    = 8;
	localparam int OFFSET_W  = 9;
	localparam int SUM_IN_W  = 10;   // int8 + 9-bit offset
	localparam int ACC_W     = 32;
	localparam int MULT_W    = 31;
	localparam int SHIFT_W   = 5;
	localparam int SCALE_W   = 36;
	localparam int PROD_W    = 63;
	localparam int CFG_ADDR_W = 4;

	// rounding nudges of the doubling high multiply
	localparam logic signed [PROD_W-1:0] NUDGE_POS = 63'sd1073741824;
	localparam logic signed [PROD_W-1:0] NUDGE_NEG = -63'sd1073741823;

	// reset values
	localparam logic [SCALE_W-1:0] SCALE_RESET = 36'd1073741824;
	localparam logic signed [ELEM_W-1:0] CLAMP_LOW_RESET  = -8'sd128;
	localparam logic signed [ELEM_W-1:0] CLAMP_HIGH_RESET = 8'sd127;

	// configuration register indexes
	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_FIRST_OFFSET  = 4'd0,
		REG_SECOND_OFFSET = 4'd1,
		REG_FIRST_SCALE   = 4'd2,
		REG_SECOND_SCALE  = 4'd3,
		REG_RESULT_SCALE  = 4'd4,
		REG_RESULT_OFFSET = 4'd5,
		REG_CLAMP_LOW     = 4'd6,
		REG_CLAMP_HIGH    = 4'd7
	} cfg_reg_t;

	typedef logic signed [ACC_W-1:0] acc_t;
	typedef logic [SCALE_W-1:0]      scale_t;

	// per-stage load enables of one rescale pipeline
	typedef struct packed {
		logic round_en;
		logic high_en;
		logic mul_en;
	} rescale_en_t;

endpackage

>>> hdl/iqea_rescale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iqea_rescale
// Three-stage fixed-point rescale: 32x31 multiply, rounding doubling high
// word, then rounding right shift (halves away from zero).
// ----------------------------------------------------------------------------
module iqea_rescale (
	input  logic                  clk,
	input  iqea_pkg::rescale_en_t en,
	input  iqea_pkg::acc_t        x,
	input  iqea_pkg::scale_t      scale,
	output iqea_pkg::acc_t        y
);
	import iqea_pkg::*;

	logic signed [PROD_W-1:0]  prod_s1;
	logic signed [2*ACC_W-1:0] prod_full;
	logic signed [PROD_W-1:0]  nudged;
	acc_t                      hm_s2;
	acc_t                      hm_next;
	logic [SHIFT_W-1:0]        shamt;
	logic [ACC_W-1:0]          mask;
	logic [ACC_W-1:0]          rem;
	logic [ACC_W-1:0]          thr;
	acc_t                      quot;
	acc_t                      y_s3;

	// stage 1: signed product with the non-negative multiplier
	assign prod_full = x * $signed({1'b0, scale[MULT_W-1:0]});

	always_ff @(posedge clk) begin
		if (en.mul_en) begin
			prod_s1 <= prod_full[PROD_W-1:0];
		end
	end

	// stage 2: add nudge, divide by 2^31 truncating toward zero
	assign nudged  = prod_s1 + (prod_s1[PROD_W-1] ? NUDGE_NEG : NUDGE_POS);
	assign hm_next = nudged[PROD_W-1:MULT_W]
		+ {{(ACC_W-1){1'b0}}, nudged[PROD_W-1] & (|nudged[MULT_W-1:0])};

	always_ff @(posedge clk) begin
		if (en.high_en) begin
			hm_s2 <= hm_next;
		end
	end

	// stage 3: rounding arithmetic right shift
	assign shamt = scale[SCALE_W-1:MULT_W];
	assign mask  = (ACC_W'(1) << shamt) - ACC_W'(1);
	assign rem   = hm_s2 & mask;
	assign thr   = {1'b0, mask[ACC_W-1:1]} + {{(ACC_W-1){1'b0}}, hm_s2[ACC_W-1]};
	assign quot  = hm_s2 >>> shamt;

	always_ff @(posedge clk) begin
		if (en.round_en) begin
			y_s3 <= quot + {{(ACC_W-1){1'b0}}, (rem > thr)};
		end
	end

	assign y = y_s3;

endmodule

>>> hdl/int8_quantized_elementwise_add_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int8_quantized_elementwise_add_unit
// Quantized int8 elementwise add: offset, pre-shift, rescale both inputs,
// add, rescale the sum, add output offset, clamp to the activation range.
// ----------------------------------------------------------------------------
// The unit takes one pair of int8 elements per cycle when not stalled by
// output back-pressure and returns the sums in order, with tlast carried
// along. It is a nine-stage pipeline: offset add, two three-stage rescale
// pipelines in parallel (multiply, high word, rounding shift), a saturating
// sum, a three-stage rescale of the sum, and the offset-and-clamp output
// register. Each stage holds its item only while the stage ahead is full and
// stalled, so empty slots close up under output back-pressure. Configuration
// registers may be written only while no transaction is in flight.
// ----------------------------------------------------------------------------
module int8_quantized_elementwise_add_unit #(
	parameter int PRE_SHIFT = 20    // 0..20
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// input stream
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [2*iqea_pkg::ELEM_W-1:0]    s_axis_tdata,  // first_value, second_value
	input  logic                             s_axis_tlast,  // last_in
	// output stream
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [iqea_pkg::ELEM_W-1:0]      m_axis_tdata,  // sum_value
	output logic                             m_axis_tlast,  // last_out
	// configuration write
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [iqea_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [iqea_pkg::SCALE_W-1:0]     cfg_data
);
	import iqea_pkg::*;

	localparam int NUM_STAGES = 9;

	// configuration registers
	logic signed [OFFSET_W-1:0] first_offset_q;
	logic signed [OFFSET_W-1:0] second_offset_q;
	scale_t                     first_scale_q;
	scale_t                     second_scale_q;
	scale_t                     result_scale_q;
	logic signed [ELEM_W-1:0]   result_offset_q;
	logic signed [ELEM_W-1:0]   clamp_low_q;
	logic signed [ELEM_W-1:0]   clamp_high_q;

	// pipeline control
	logic [NUM_STAGES:1]   vld_q;
	logic [NUM_STAGES:1]   last_q;
	logic [NUM_STAGES+1:1] en;
	logic [NUM_STAGES:0]   vld_in;
	logic [NUM_STAGES:0]   last_in;
	rescale_en_t           en_in_scale;
	rescale_en_t           en_res_scale;

	// datapath
	logic signed [SUM_IN_W-1:0] a_s1;
	logic signed [SUM_IN_W-1:0] b_s1;
	acc_t                       sa;
	acc_t                       sb;
	acc_t                       ya;
	acc_t                       yb;
	logic signed [ACC_W:0]      sum_wide;
	acc_t                       sum_s5;
	acc_t                       yr;
	logic signed [ACC_W:0]      r_wide;
	logic signed [ACC_W:0]      lo_wide;
	logic signed [ACC_W:0]      hi_wide;
	logic signed [ACC_W:0]      r_clamped;
	logic [ELEM_W-1:0]          out_s9;

	// configuration writes, out-of-range indexes ignored
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_offset_q  <= '0;
			second_offset_q <= '0;
			first_scale_q   <= SCALE_RESET;
			second_scale_q  <= SCALE_RESET;
			result_scale_q  <= SCALE_RESET;
			result_offset_q <= '0;
			clamp_low_q     <= CLAMP_LOW_RESET;
			clamp_high_q    <= CLAMP_HIGH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_addr)
				REG_FIRST_OFFSET:  first_offset_q  <= cfg_data[OFFSET_W-1:0];
				REG_SECOND_OFFSET: second_offset_q <= cfg_data[OFFSET_W-1:0];
				REG_FIRST_SCALE:   first_scale_q   <= cfg_data;
				REG_SECOND_SCALE:  second_scale_q  <= cfg_data;
				REG_RESULT_SCALE:  result_scale_q  <= cfg_data;
				REG_RESULT_OFFSET: result_offset_q <= cfg_data[ELEM_W-1:0];
				REG_CLAMP_LOW:     clamp_low_q     <= cfg_data[ELEM_W-1:0];
				REG_CLAMP_HIGH:    clamp_high_q    <= cfg_data[ELEM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// stage enables: a stage loads when empty or when the next one moves
	always_comb begin
		en[NUM_STAGES+1] = m_axis_tready;
		for (int k = NUM_STAGES; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign vld_in  = {vld_q, s_axis_tvalid};
	assign last_in = {last_q, s_axis_tlast};

	// valid bits and tlast travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 1; k <= NUM_STAGES; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_in[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 1; k <= NUM_STAGES; k++) begin
			if (en[k]) begin
				last_q[k] <= last_in[k-1];
			end
		end
	end

	assign s_axis_tready = en[1];

	// stage 1: add input offsets
	always_ff @(posedge clk) begin
		if (en[1]) begin
			a_s1 <= SUM_IN_W'($signed(s_axis_tdata[ELEM_W-1:0])) + SUM_IN_W'(first_offset_q);
			b_s1 <= SUM_IN_W'($signed(s_axis_tdata[2*ELEM_W-1:ELEM_W]))
				+ SUM_IN_W'(second_offset_q);
		end
	end

	// pre-shift is wiring; the result always fits in 32 bits
	assign sa = ACC_W'(a_s1) <<< PRE_SHIFT;
	assign sb = ACC_W'(b_s1) <<< PRE_SHIFT;

	// stages 2..4: rescale each input
	assign en_in_scale = '{round_en: en[4], high_en: en[3], mul_en: en[2]};

	iqea_rescale u_rescale_first (
		.clk   (clk),
		.en    (en_in_scale),
		.x     (sa),
		.scale (first_scale_q),
		.y     (ya)
	);

	iqea_rescale u_rescale_second (
		.clk   (clk),
		.en    (en_in_scale),
		.x     (sb),
		.scale (second_scale_q),
		.y     (yb)
	);

	// stage 5: saturating sum
	assign sum_wide = (ACC_W+1)'(ya) + (ACC_W+1)'(yb);

	always_ff @(posedge clk) begin
		if (en[5]) begin
			if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
				sum_s5 <= sum_wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
					: {1'b0, {(ACC_W-1){1'b1}}};
			end else begin
				sum_s5 <= sum_wide[ACC_W-1:0];
			end
		end
	end

	// stages 6..8: rescale the sum
	assign en_res_scale = '{round_en: en[8], high_en: en[7], mul_en: en[6]};

	iqea_rescale u_rescale_result (
		.clk   (clk),
		.en    (en_res_scale),
		.x     (sum_s5),
		.scale (result_scale_q),
		.y     (yr)
	);

	// stage 9: output offset and clamp, low bound first then high bound
	assign r_wide  = (ACC_W+1)'(yr) + (ACC_W+1)'(result_offset_q);
	assign lo_wide = (ACC_W+1)'(clamp_low_q);
	assign hi_wide = (ACC_W+1)'(clamp_high_q);

	always_comb begin
		r_clamped = r_wide;
		if (r_clamped < lo_wide) begin
			r_clamped = lo_wide;
		end
		if (r_clamped > hi_wide) begin
			r_clamped = hi_wide;
		end
	end

	always_ff @(posedge clk) begin
		if (en[9]) begin
			out_s9 <= r_clamped[ELEM_W-1:0];
		end
	end

	assign m_axis_tvalid = vld_q[NUM_STAGES];
	assign m_axis_tdata  = out_s9;
	assign m_axis_tlast  = last_q[NUM_STAGES];

endmodule
